// ----- hw/rtl/stq_pkg.sv -----
// Shared types and codes for the sorted timer queue.
// Used by stq_ctrl, stq_dp and sorted_timer_queue; depends on nothing.
package stq_pkg;

  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_POSTED    = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_EXPIRY    = 3'd3,
    KIND_IDLE      = 3'd4
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] delay;
    logic [23:0] interval;
    logic [31:0] cancel_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] message_id;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] deadline;
    logic [23:0] period;
    logic        immediate;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_START    = 4'd1,
    CMD_INS_RD   = 4'd2,
    CMD_INS_WR   = 4'd3,
    CMD_CMP_RD   = 4'd4,
    CMD_CMP_WR   = 4'd5,
    CMD_DUE_RD   = 4'd6,
    CMD_DUE_EMIT = 4'd7,
    CMD_RESULT   = 4'd8
  } step_t;

  typedef struct packed {
    step_t step;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic k_zero;
    logic ins_stop;
    logic cmp_end;
    logic ndue_zero;
    logic due_per_nz;
    logic due_last;
    logic slot_free;
  } stat_t;

endpackage

// ----- hw/rtl/stq_ctrl.sv -----
// Sequencing state machine for the sorted timer queue.
// Depends on stq_pkg; drives commands into stq_dp and reads its status.
module stq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_stall,
  input  stq_pkg::stat_t    st,
  output stq_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_RD   = 8'b0000_0010,
    S_INS_WR   = 8'b0000_0100,
    S_CMP_RD   = 8'b0000_1000,
    S_CMP_WR   = 8'b0001_0000,
    S_DUE_RD   = 8'b0010_0000,
    S_DUE_EMIT = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  stq_pkg::kind_t      kind_r, kind_nxt;
  logic                last_r, last_nxt;
  state_t              ins_done_state;

  assign in_stall = (state_r != S_IDLE);

  // where an insertion returns to
  always_comb begin
    if (op_r == stq_pkg::OP_POST) begin
      ins_done_state = S_RESULT;
    end else if (last_r) begin
      ins_done_state = S_IDLE;
    end else begin
      ins_done_state = S_DUE_RD;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    cmd.step  = stq_pkg::CMD_NONE;
    cmd.kind  = kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = stq_pkg::CMD_START;
          op_nxt   = in_op;
          case (in_op)
            stq_pkg::OP_POST: begin
              if (st.full) begin
                kind_nxt  = stq_pkg::KIND_REJECTED;
                state_nxt = S_RESULT;
              end else begin
                kind_nxt  = stq_pkg::KIND_POSTED;
                state_nxt = S_INS_RD;
              end
            end
            stq_pkg::OP_CANCEL: begin
              kind_nxt  = stq_pkg::KIND_CANCELLED;
              state_nxt = S_CMP_RD;
            end
            stq_pkg::OP_TICK: begin
              kind_nxt  = stq_pkg::KIND_IDLE;
              state_nxt = S_CMP_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        cmd.step  = stq_pkg::CMD_INS_RD;
        state_nxt = st.k_zero ? ins_done_state : S_INS_WR;
      end
      S_INS_WR: begin
        cmd.step  = stq_pkg::CMD_INS_WR;
        state_nxt = st.ins_stop ? ins_done_state : S_INS_RD;
      end
      S_CMP_RD: begin
        cmd.step = stq_pkg::CMD_CMP_RD;
        if (!st.cmp_end) begin
          state_nxt = S_CMP_WR;
        end else if (op_r == stq_pkg::OP_CANCEL || st.ndue_zero) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_DUE_RD;
        end
      end
      S_CMP_WR: begin
        cmd.step  = stq_pkg::CMD_CMP_WR;
        state_nxt = S_CMP_RD;
      end
      S_DUE_RD: begin
        cmd.step  = stq_pkg::CMD_DUE_RD;
        state_nxt = S_DUE_EMIT;
      end
      S_DUE_EMIT: begin
        if (st.slot_free) begin
          cmd.step = stq_pkg::CMD_DUE_EMIT;
          last_nxt = st.due_last;
          if (st.due_per_nz) begin
            state_nxt = S_INS_RD;
          end else if (st.due_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DUE_RD;
          end
        end
      end
      S_RESULT: begin
        if (st.slot_free) begin
          cmd.step  = stq_pkg::CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r   <= op_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- hw/rtl/stq_dp.sv -----
// Datapath of the sorted timer queue: timer table, due list, counters, result register.
// Depends on stq_pkg; sequenced by stq_ctrl.
module stq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  stq_pkg::in_t     in_data,
  input  stq_pkg::cmd_t    cmd,
  output stq_pkg::stat_t   st,
  output logic             out_valid,
  input  logic             out_stall,
  output stq_pkg::out_t    out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::entry_t tbl_mem [QUEUE_DEPTH];
  stq_pkg::entry_t due_mem [QUEUE_DEPTH];

  stq_pkg::entry_t tbl_q, due_q, ins_r, reins;
  logic [CW-1:0]   cnt_r, k_r, r_r, w_r, ndue_r, j_r, k_m1;
  logic [47:0]     now_r, reins_base;
  logic [31:0]     nid_r, cid_r;
  logic [1:0]      op_r;
  logic            out_valid_r;
  stq_pkg::out_t   out_r;
  logic            remove;

  logic            tbl_we, tbl_re, due_we, due_re;
  logic [AW-1:0]   tbl_waddr, tbl_raddr, due_waddr, due_raddr;
  stq_pkg::entry_t tbl_wdata;

  assign k_m1 = k_r - CW'(1);

  assign remove = (op_r == stq_pkg::OP_CANCEL) ? (tbl_q.id == cid_r)
                : (tbl_q.immediate || (now_r >= tbl_q.deadline));

  assign reins_base      = due_q.immediate ? now_r : due_q.deadline;
  assign reins.id        = due_q.id;
  assign reins.deadline  = reins_base + {24'd0, due_q.period};
  assign reins.period    = due_q.period;
  assign reins.immediate = 1'b0;

  assign st.full       = (cnt_r == CW'(QUEUE_DEPTH));
  assign st.k_zero     = (k_r == '0);
  assign st.ins_stop   = tbl_q.immediate
                       || (!ins_r.immediate && (tbl_q.deadline <= ins_r.deadline));
  assign st.cmp_end    = (r_r == cnt_r);
  assign st.ndue_zero  = (ndue_r == '0);
  assign st.due_per_nz = (due_q.period != '0);
  assign st.due_last   = ((j_r + CW'(1)) == ndue_r);
  assign st.slot_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    due_we    = 1'b0;
    due_re    = 1'b0;
    tbl_waddr = k_r[AW-1:0];
    tbl_raddr = r_r[AW-1:0];
    due_waddr = ndue_r[AW-1:0];
    due_raddr = j_r[AW-1:0];
    tbl_wdata = ins_r;
    case (cmd.step)
      stq_pkg::CMD_INS_RD: begin
        if (st.k_zero) begin
          tbl_we    = 1'b1;
          tbl_waddr = '0;
        end else begin
          tbl_re    = 1'b1;
          tbl_raddr = k_m1[AW-1:0];
        end
      end
      stq_pkg::CMD_INS_WR: begin
        // shift the larger entry up one slot, or drop the new one in
        tbl_we    = 1'b1;
        tbl_wdata = st.ins_stop ? ins_r : tbl_q;
      end
      stq_pkg::CMD_CMP_RD: tbl_re = !st.cmp_end;
      stq_pkg::CMD_CMP_WR: begin
        if (!remove) begin
          tbl_we    = 1'b1;
          tbl_waddr = w_r[AW-1:0];
          tbl_wdata = tbl_q;
        end else if (op_r == stq_pkg::OP_TICK) begin
          due_we = 1'b1;
        end
      end
      stq_pkg::CMD_DUE_RD: due_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= tbl_q;
    end
    if (due_re) begin
      due_q <= due_mem[due_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      now_r       <= '0;
      nid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result loaded this cycle keeps the register valid
      if (out_valid_r && !out_stall && cmd.step != stq_pkg::CMD_DUE_EMIT
          && cmd.step != stq_pkg::CMD_RESULT) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.step)
        stq_pkg::CMD_START: begin
          op_r   <= in_data.operation;
          cid_r  <= in_data.cancel_id;
          r_r    <= '0;
          w_r    <= '0;
          ndue_r <= '0;
          j_r    <= '0;
          k_r    <= cnt_r;
          if (in_data.operation == stq_pkg::OP_POST && !st.full) begin
            ins_r.id        <= nid_r;
            ins_r.immediate <= (in_data.delay == '0);
            ins_r.deadline  <= (in_data.delay == '0) ? 48'd0
                             : now_r + {24'd0, in_data.delay};
            ins_r.period    <= in_data.interval;
            nid_r           <= nid_r + 32'd1;
          end
          if (in_data.operation == stq_pkg::OP_TICK) begin
            now_r <= now_r + 48'd1;
          end
        end
        stq_pkg::CMD_INS_RD: begin
          if (st.k_zero) begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        stq_pkg::CMD_INS_WR: begin
          if (st.ins_stop) begin
            cnt_r <= cnt_r + CW'(1);
          end else begin
            k_r <= k_m1;
          end
        end
        stq_pkg::CMD_CMP_RD: begin
          if (st.cmp_end) begin
            cnt_r <= w_r;
          end
        end
        stq_pkg::CMD_CMP_WR: begin
          r_r <= r_r + CW'(1);
          if (!remove) begin
            w_r <= w_r + CW'(1);
          end else if (op_r == stq_pkg::OP_TICK) begin
            ndue_r <= ndue_r + CW'(1);
          end
        end
        stq_pkg::CMD_DUE_EMIT: begin
          out_valid_r      <= 1'b1;
          out_r.kind       <= stq_pkg::KIND_EXPIRY;
          out_r.message_id <= due_q.id;
          out_r.last       <= st.due_last;
          j_r              <= j_r + CW'(1);
          if (st.due_per_nz) begin
            ins_r <= reins;
            k_r   <= cnt_r;
          end
        end
        stq_pkg::CMD_RESULT: begin
          out_valid_r <= 1'b1;
          out_r.kind  <= cmd.kind;
          out_r.last  <= 1'b1;
          case (cmd.kind)
            stq_pkg::KIND_POSTED:    out_r.message_id <= ins_r.id;
            stq_pkg::KIND_CANCELLED: out_r.message_id <= cid_r;
            default:                 out_r.message_id <= '0;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sorted_timer_queue.sv -----
// Sorted timer queue: a deadline-ordered table of up to QUEUE_DEPTH timers with post,
// cancel and tick operations. One operation is worked at a time; the table sits in a
// single-write, registered-read memory and every table walk steps through its entries
// with a read state and a write state. Post: walk from the table tail down to the insert
// point, shifting later entries up, then report; a rejected post reports at once.
// Cancel: compact the whole table, then report. Tick: compact the table, moving due
// entries to the due list; report idle when nothing is due, else emit each expiry in turn
// and re-insert a periodic timer with the post walk. A stalled output holds each result
// back until the output register is free. A new operation is taken once the last result
// sits in the output register and any re-insert has finished. Depends on stq_pkg, stq_ctrl and stq_dp.
module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  stq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output stq_pkg::out_t  out_data
);

  stq_pkg::cmd_t  cmd;
  stq_pkg::stat_t st;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  stq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // any valid operation that is accepted makes the block busy in the following cycle
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == stq_pkg::OP_POST
      || in_data.operation == stq_pkg::OP_CANCEL || in_data.operation == stq_pkg::OP_TICK)
    |=> in_stall)
    else $error("operation accepted without going busy");

  // only expiries can be non-final results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != stq_pkg::KIND_EXPIRY |-> out_data.last)
    else $error("non-expiry result without last");

  // a post is rejected only when the table is full
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step == stq_pkg::CMD_START && in_data.operation == stq_pkg::OP_POST && !st.full
    |=> !(cmd.kind == stq_pkg::KIND_REJECTED))
    else $error("post rejected with room in table");

endmodule

// ----- tb/testbench.sv -----
// Testbench for sorted_timer_queue: random and directed post, cancel and tick traffic.
// Depends on stq_pkg and the sorted_timer_queue RTL; predicts results with its own timer table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  stq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stq_pkg::out_t out_data;

  sorted_timer_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: the timer table
  logic [31:0] tbl_id [DEPTH];
  logic [47:0] tbl_dl [DEPTH];
  logic [23:0] tbl_per [DEPTH];
  logic        tbl_imm [DEPTH];
  int          tbl_cnt = 0;
  logic [47:0] now_t = '0;
  logic [31:0] id_ctr = '0;
  logic [31:0] live_ids [$];

  stq_pkg::in_t  pending_q [$];
  stq_pkg::out_t expected_q [$];
  int   errors = 0;
  int   cycles = 0;
  int   gap = 0;
  int   ostall_left = 0;
  bit   hold_off = 1'b0;

  function automatic void table_insert(logic [31:0] id, logic imm, logic [47:0] dl,
                                       logic [23:0] per);
    int pos;
    pos = 0;
    while (pos < tbl_cnt && (tbl_imm[pos] || (!imm && tbl_dl[pos] <= dl))) pos++;
    for (int k = tbl_cnt; k > pos; k--) begin
      tbl_id[k] = tbl_id[k-1];
      tbl_dl[k] = tbl_dl[k-1];
      tbl_per[k] = tbl_per[k-1];
      tbl_imm[k] = tbl_imm[k-1];
    end
    tbl_id[pos] = id;
    tbl_dl[pos] = dl;
    tbl_per[pos] = per;
    tbl_imm[pos] = imm;
    tbl_cnt++;
  endfunction

  function automatic stq_pkg::out_t mk(stq_pkg::kind_t k, logic [31:0] id, logic l);
    stq_pkg::out_t r;
    r.kind = k;
    r.message_id = id;
    r.last = l;
    return r;
  endfunction

  function automatic void add_expected(stq_pkg::out_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void add_pending(stq_pkg::in_t t);
    pending_q.insert(pending_q.size(), t);
  endfunction

  function automatic void predict_timer_op(stq_pkg::in_t t);
    logic [31:0] d_id [DEPTH];
    logic [47:0] d_dl [DEPTH];
    logic [23:0] d_per [DEPTH];
    logic        d_imm [DEPTH];
    int nd, w;
    nd = 0;
    w = 0;
    case (t.operation)
      stq_pkg::OP_POST: begin
        if (tbl_cnt >= DEPTH) begin
          add_expected(mk(stq_pkg::KIND_REJECTED, '0, 1'b1));
        end else begin
          table_insert(id_ctr, t.delay == 0, (t.delay == 0) ? 48'd0 : now_t + t.delay,
                       t.interval);
          add_expected(mk(stq_pkg::KIND_POSTED, id_ctr, 1'b1));
          id_ctr++;
        end
      end
      stq_pkg::OP_CANCEL: begin
        for (int r = 0; r < tbl_cnt; r++) begin
          if (tbl_id[r] != t.cancel_id) begin
            tbl_id[w] = tbl_id[r];
            tbl_dl[w] = tbl_dl[r];
            tbl_per[w] = tbl_per[r];
            tbl_imm[w] = tbl_imm[r];
            w++;
          end
        end
        tbl_cnt = w;
        add_expected(mk(stq_pkg::KIND_CANCELLED, t.cancel_id, 1'b1));
      end
      stq_pkg::OP_TICK: begin
        now_t++;
        for (int r = 0; r < tbl_cnt; r++) begin
          if (tbl_imm[r] || now_t >= tbl_dl[r]) begin
            d_id[nd] = tbl_id[r];
            d_dl[nd] = tbl_dl[r];
            d_per[nd] = tbl_per[r];
            d_imm[nd] = tbl_imm[r];
            nd++;
          end else begin
            tbl_id[w] = tbl_id[r];
            tbl_dl[w] = tbl_dl[r];
            tbl_per[w] = tbl_per[r];
            tbl_imm[w] = tbl_imm[r];
            w++;
          end
        end
        tbl_cnt = w;
        if (nd == 0) add_expected(mk(stq_pkg::KIND_IDLE, '0, 1'b1));
        for (int r = 0; r < nd; r++) begin
          add_expected(mk(stq_pkg::KIND_EXPIRY, d_id[r], r == nd - 1));
          if (d_per[r] != 0)
            table_insert(d_id[r], 1'b0, (d_imm[r] ? now_t : d_dl[r]) + d_per[r], d_per[r]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic stq_pkg::in_t mk_op(stq_pkg::op_t op, logic [23:0] dly, logic [23:0] itv,
                                         logic [31:0] cid);
    stq_pkg::in_t t;
    t.operation = op;
    t.delay = dly;
    t.interval = itv;
    t.cancel_id = cid;
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_timer_op(in_data);
        if (in_data.operation == stq_pkg::OP_POST) live_ids.insert(live_ids.size(), id_ctr - 1);
      end
      if (!(in_valid && in_stall)) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_off) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      // output stalls come in runs, mostly short and now and then long
      if (ostall_left > 0) begin
        ostall_left <= ostall_left - 1;
        out_stall <= 1'b1;
      end else begin
        ostall_left <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result kind=%0d id=%h last=%b", $time,
                 out_data.kind, out_data.message_id, out_data.last);
      end else begin
        stq_pkg::out_t e;
        e = expected_q.pop_front();
        if (e.kind != out_data.kind) begin
          errors++;
          $display("%0t kind: expected %0d actual %0d", $time, e.kind, out_data.kind);
        end
        if (e.message_id != out_data.message_id) begin
          errors++;
          $display("%0t message_id: expected %h actual %h", $time, e.message_id,
                   out_data.message_id);
        end
        if (e.last != out_data.last) begin
          errors++;
          $display("%0t last: expected %b actual %b", $time, e.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("sorted_timer_queue verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int n, p;
    logic [31:0] cid;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ticks on empty, immediates, extremes, equal deadlines, full, unknown op
    add_pending(mk_op(stq_pkg::OP_TICK, '0, '0, '0));
    add_pending(mk_op(stq_pkg::OP_POST, 24'd0, 24'd0, '1));
    add_pending(mk_op(stq_pkg::OP_POST, 24'd0, 24'd3, '0));
    add_pending(mk_op(stq_pkg::OP_POST, 24'd2, 24'd0, '0));
    add_pending(mk_op(stq_pkg::OP_POST, 24'd2, 24'hFFFFFF, '0));
    add_pending(mk_op(stq_pkg::OP_POST, 24'hFFFFFF, 24'd1, '0));
    add_pending(mk_op(stq_pkg::OP_POST, 24'h555555, 24'hAAAAAA, 32'hAAAA5555));
    add_pending(mk_op(stq_pkg::OP_CANCEL, '0, '0, 32'd5));
    add_pending(mk_op(stq_pkg::OP_CANCEL, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF));
    add_pending(stq_pkg::in_t'({2'd3, 24'h123456, 24'h654321, 32'h5A5A5A5A}));
    for (int i = 0; i < 5; i++) add_pending(mk_op(stq_pkg::OP_TICK, '0, '0, '0));
    for (int i = 0; i < 14; i++) add_pending(mk_op(stq_pkg::OP_POST, 24'd1, 24'd0, '0));
    add_pending(mk_op(stq_pkg::OP_TICK, '0, '0, '0));
    wait_drained();
    // fill completely, then reject
    for (int i = 0; i < 17; i++) add_pending(mk_op(stq_pkg::OP_POST, 24'd3, 24'd1, '0));
    for (int i = 0; i < 4; i++) add_pending(mk_op(stq_pkg::OP_TICK, '0, '0, '0));
    // once everything has drained, the sender holds off with cancels queued, then releases them
    wait_drained();
    hold_off = 1'b1;
    for (int i = 0; i < 16; i++)
      add_pending(mk_op(stq_pkg::OP_CANCEL, '0, '0, id_ctr - 1 - i));
    repeat (20) @(posedge clk);
    hold_off = 1'b0;

    // random phase
    n = 0;
    while (n < 300) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        logic [23:0] d, iv;
        d = ($urandom_range(0, 9) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 6));
        iv = ($urandom_range(0, 9) == 0) ? 24'($urandom()) :
             ($urandom_range(0, 1) ? 24'd0 : 24'($urandom_range(1, 5)));
        add_pending(mk_op(stq_pkg::OP_POST, d, iv, $urandom()));
      end else if (p < 57) begin
        cid = (live_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
              live_ids[$urandom_range(0, live_ids.size() - 1)] : $urandom();
        add_pending(mk_op(stq_pkg::OP_CANCEL, 24'($urandom()), 24'($urandom()), cid));
      end else if (p < 98) begin
        add_pending(mk_op(stq_pkg::OP_TICK, 24'($urandom()), 24'($urandom()), $urandom()));
      end else begin
        add_pending(stq_pkg::in_t'({2'd3, 24'($urandom()), 24'($urandom()),
                                    32'($urandom())}));
        n--;
      end
      n++;
      if (n % 40 == 0) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("sorted_timer_queue verification clean");
    end else begin
      $display("sorted_timer_queue verification failed");
    end
    $finish;
  end
endmodule

// ----- sorted_timer_queue.f -----
hw/rtl/stq_pkg.sv
hw/rtl/stq_ctrl.sv
hw/rtl/stq_dp.sv
hw/rtl/sorted_timer_queue.sv
tb/testbench.sv
